/* src/clms_pkg.sv */
// shared types and constants of the circular local mean subtract block
// used by clms_div and circular_local_mean_subtract_core; no dependencies
package clms_pkg;

	// fixed widths of the item fields
	localparam int CH_W    = 8;
	localparam int COORD_W = 7;
	localparam int RAD_W   = 4;
	// signed window offset, holds -15..15
	localparam int OFS_W   = 6;
	// window holds at most 31 x 31 pixels
	localparam int CNT_W   = 10;
	localparam int SUM_W   = CH_W + CNT_W;
	// mean never exceeds 255, so the quotient has eight bits
	localparam int QUO_W   = CH_W;
	localparam int STEP_W  = 3;

	// configuration port
	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;
	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// input kind on tuser
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// result status on tuser
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_DRAIN  = 6'b000100,
		ST_CENTRE = 6'b001000,
		ST_DIVIDE = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	// request to the shared divider
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	// answer from the shared divider
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quot;
	} div_rsp_t;

	// magnitude of a window offset
	function automatic logic [RAD_W-1:0] ofs_abs(input logic signed [OFS_W-1:0] v);
		logic [OFS_W-1:0] m;
		m = v[OFS_W-1] ? OFS_W'(-v) : OFS_W'(v);
		return m[RAD_W-1:0];
	endfunction

endpackage

/* src/clms_div.sv */
// shared restoring divider for the neighbourhood mean, one quotient bit per cycle
// depends on clms_pkg
module clms_div
	import clms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0] rem_q;
	logic [CNT_W-1:0] div_q;
	logic [QUO_W-1:0] quot_q;
	logic [SUM_W-1:0] trial;
	logic             fits;

	// shifted divisor for the current quotient bit
	always_comb begin
		trial = SUM_W'(div_q) << step_q;
		fits  = rem_q >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			div_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q && fits) begin
			rem_q          <= rem_q - trial;
			quot_q[step_q] <= 1'b1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

/* src/circular_local_mean_subtract_core.sv */
// A load word writes one RGB pixel into the on-chip pixel store. A query word scans the
// (2r+1) x (2r+1) square around the centre and reads the store, through its single read
// port, for the pixels inside the circle and the image, then reads the centre and divides
// the three channel sums by the pixel count in one shared divider. A query outside the
// image skips the scan and the division and gives an error status with zero data.
// One word is worked on at a time; a new word is taken while the previous result still
// waits in the output register. The store has no reset: only pixels that were loaded
// may be named by a query.
// depends on clms_pkg and clms_div
module circular_local_mean_subtract_core
	import clms_pkg::*;
#(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int MAX_RADIUS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	// input words
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,  // col, row, red_in, green_in, blue_in, zero pad
	input  logic              s_tuser,  // func
	// results
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,  // red_out, green_out, blue_out
	output logic              m_tuser   // status
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0]    WIDTH_A = AW'(MAX_WIDTH);
	localparam logic [RAD_W-1:0] RAD_MAX = (MAX_RADIUS > 15) ? 4'd15 : RAD_W'(MAX_RADIUS);
	localparam logic [7:0]       W_MAX   = (MAX_WIDTH > 255) ? 8'd255 : 8'(MAX_WIDTH);
	localparam logic [7:0]       H_MAX   = (MAX_HEIGHT > 255) ? 8'd255 : 8'(MAX_HEIGHT);

	// configuration registers
	logic [RAD_W-1:0] radius_q;
	logic [7:0]       image_width_q;
	logic [7:0]       image_height_q;
	logic             cfg_wr;

	// control
	state_t state_q;
	logic   in_acc;
	logic   load_acc;
	logic   query_acc;

	// input fields
	logic [COORD_W-1:0] in_col;
	logic [COORD_W-1:0] in_row;
	logic [3*CH_W-1:0]  in_pixel;

	// query context
	logic [COORD_W-1:0]      col_q;
	logic [COORD_W-1:0]      row_q;
	logic [7:0]              w_q;
	logic [7:0]              h_q;
	logic [RAD_W-1:0]        rad_q;
	logic [2*RAD_W-1:0]      rr_q;
	logic signed [OFS_W-1:0] dc_q;
	logic signed [OFS_W-1:0] dr_q;
	logic [7:0]              w_cap;
	logic [7:0]              h_cap;
	logic [RAD_W-1:0]        rad_cap;
	logic signed [OFS_W-1:0] rad_s;
	logic                    q_err;

	// window position
	logic signed [8:0]  xc;
	logic signed [8:0]  yc;
	logic [RAD_W-1:0]   adc;
	logic [RAD_W-1:0]   adr;
	logic [2*RAD_W:0]   dist_sq;
	logic               in_circle;
	logic               in_img;
	logic               take;
	logic               scan_last;
	logic [AW-1:0]      scan_addr;
	logic [AW-1:0]      centre_addr;

	// pixel store
	logic [3*CH_W-1:0] mem [DEPTH];
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [3*CH_W-1:0] rd_data_q;
	logic              rd_valid_s1;

	// accumulators
	logic [SUM_W-1:0]  sum_r_q;
	logic [SUM_W-1:0]  sum_g_q;
	logic [SUM_W-1:0]  sum_b_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [3*CH_W-1:0] centre_q;

	// division and result
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic [1:0]        ch_q;
	logic [1:0]        ch_next;
	logic [CH_W-1:0]   centre_ch;
	logic [CH_W-1:0]   res_q [3];
	logic              err_q;
	logic              out_free;

	// apb register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q       <= 4'd1;
			image_width_q  <= 8'd128;
			image_height_q <= 8'd128;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_RADIUS: radius_q       <= pwdata[RAD_W-1:0];
				REG_WIDTH:  image_width_q  <= pwdata[7:0];
				REG_HEIGHT: image_height_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RADIUS: prdata = CFG_DW'(radius_q);
			REG_WIDTH:  prdata = CFG_DW'(image_width_q);
			REG_HEIGHT: prdata = CFG_DW'(image_height_q);
			default:    prdata = '0;
		endcase
	end

	// input word decode
	assign in_col    = s_tdata[6:0];
	assign in_row    = s_tdata[13:7];
	assign in_pixel  = {s_tdata[21:14], s_tdata[29:22], s_tdata[37:30]};
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign load_acc  = in_acc && (s_tuser == FUNC_LOAD);
	assign query_acc = in_acc && (s_tuser == FUNC_QUERY);

	// limits of the configured image and radius
	always_comb begin
		w_cap   = (image_width_q > W_MAX) ? W_MAX : image_width_q;
		h_cap   = (image_height_q > H_MAX) ? H_MAX : image_height_q;
		rad_cap = (radius_q > RAD_MAX) ? RAD_MAX : radius_q;
		q_err   = ({1'b0, in_col} >= w_cap) || ({1'b0, in_row} >= h_cap);
		rad_s   = $signed(OFS_W'(rad_q));
	end

	// current window point
	always_comb begin
		xc        = $signed({2'b00, col_q}) + 9'(dc_q);
		yc        = $signed({2'b00, row_q}) + 9'(dr_q);
		adc       = ofs_abs(dc_q);
		adr       = ofs_abs(dr_q);
		dist_sq   = (2*RAD_W+1)'(adc) * (2*RAD_W+1)'(adc)
			+ (2*RAD_W+1)'(adr) * (2*RAD_W+1)'(adr);
		in_circle = dist_sq <= {1'b0, rr_q};
		in_img    = !xc[8] && (xc[7:0] < w_q) && !yc[8] && (yc[7:0] < h_q);
		take      = (state_q == ST_SCAN) && in_circle && in_img;
		scan_last = (dc_q == rad_s) && (dr_q == rad_s);
		scan_addr   = AW'(yc[7:0]) * WIDTH_A + AW'(xc[7:0]);
		centre_addr = AW'(row_q) * WIDTH_A + AW'(col_q);
	end

	// store ports
	always_comb begin
		wr_en   = load_acc && ({25'd0, in_col} < 32'(MAX_WIDTH))
			&& ({25'd0, in_row} < 32'(MAX_HEIGHT));
		wr_addr = AW'(in_row) * WIDTH_A + AW'(in_col);
		rd_en   = take || (state_q == ST_DRAIN);
		rd_addr = (state_q == ST_DRAIN) ? centre_addr : scan_addr;
	end

	// loads write only at acceptance in the idle state and reads happen only in the scan and
	// drain states, where no word is accepted, so no entry is read and written in the same cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= in_pixel;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
			ch_q        <= '0;
		end else begin
			rd_valid_s1 <= take;
			unique case (state_q)
				ST_IDLE: begin
					if (query_acc) begin
						state_q <= q_err ? ST_RESULT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CENTRE;
				end
				ST_CENTRE: begin
					ch_q    <= '0;
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_rsp.done) begin
						if (ch_q == 2'd2) begin
							state_q <= ST_RESULT;
						end else begin
							ch_q <= ch_next;
						end
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query context and window counters
	always_ff @(posedge clk) begin
		if (query_acc) begin
			col_q <= in_col;
			row_q <= in_row;
			w_q   <= w_cap;
			h_q   <= h_cap;
			rad_q <= rad_cap;
			rr_q  <= (2*RAD_W)'(rad_cap) * (2*RAD_W)'(rad_cap);
			dc_q  <= -$signed(OFS_W'(rad_cap));
			dr_q  <= -$signed(OFS_W'(rad_cap));
			err_q <= q_err;
		end else if (state_q == ST_SCAN) begin
			if (dr_q == rad_s) begin
				dr_q <= -rad_s;
				dc_q <= dc_q + 1'b1;
			end else begin
				dr_q <= dr_q + 1'b1;
			end
		end
	end

	// channel sums and pixel count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (query_acc) begin
			cnt_q <= '0;
		end else if (rd_valid_s1) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
		end else if (rd_valid_s1) begin
			sum_r_q <= sum_r_q + SUM_W'(rd_data_q[23:16]);
			sum_g_q <= sum_g_q + SUM_W'(rd_data_q[15:8]);
			sum_b_q <= sum_b_q + SUM_W'(rd_data_q[7:0]);
		end
		if (state_q == ST_CENTRE) begin
			centre_q <= rd_data_q;
		end
	end

	// divider requests, one channel after the other
	always_comb begin
		ch_next = (state_q == ST_CENTRE) ? 2'd0 : ch_q + 1'b1;
		div_req.start = (state_q == ST_CENTRE)
			|| ((state_q == ST_DIVIDE) && div_rsp.done && (ch_q != 2'd2));
		unique case (ch_next)
			2'd0:    div_req.dividend = sum_r_q;
			2'd1:    div_req.dividend = sum_g_q;
			default: div_req.dividend = sum_b_q;
		endcase
		div_req.divisor = cnt_q;
		unique case (ch_q)
			2'd0:    centre_ch = centre_q[23:16];
			2'd1:    centre_ch = centre_q[15:8];
			default: centre_ch = centre_q[7:0];
		endcase
	end

	clms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// centre minus mean, clamped at zero
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIVIDE) && div_rsp.done) begin
			res_q[ch_q] <= (centre_ch > div_rsp.quot) ? centre_ch - div_rsp.quot : '0;
		end
	end

	// output register
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			m_tdata <= err_q ? '0 : {res_q[2], res_q[1], res_q[0]};
			m_tuser <= err_q ? STATUS_ERR : STATUS_OK;
		end
	end

	// the centre is always part of its own window
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CENTRE) |-> (cnt_q != '0))
		else $error("pixel count is zero at the centre read");

	// every accumulated word follows a store read
	a_acc_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(rd_en))
		else $error("accumulation without a store read");

	// the divider answers only while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside the divide phase");

	// a new division never starts over a running one
	a_div_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// a pending result is never overwritten
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RESULT) && m_tvalid && !m_tready) |=> (state_q == ST_RESULT))
		else $error("result left while output register was full");

endmodule
